/* rtl/dfe_pkg.sv */
`timescale 1ns / 1ps

package dfe_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned DELIM_BYTES = 8;
  localparam int unsigned DELIM_W     = CHAR_W * DELIM_BYTES;
  localparam int unsigned LEN_W       = 4;
  localparam int unsigned PIECE_W     = 16;
  localparam int unsigned SEEN_W      = 17;
  localparam int unsigned ADDR_W      = 5;
  localparam int unsigned DATA_W      = 64;
  localparam int unsigned IDX_W       = 2;

  localparam logic [IDX_W-1:0] REG_DELIM_BYTES  = 2'd0;
  localparam logic [IDX_W-1:0] REG_DELIM_LENGTH = 2'd1;
  localparam logic [IDX_W-1:0] REG_PIECE_NUMBER = 2'd2;

  localparam logic [LEN_W-1:0] DELIM_LEN_RST = 4'd1;

  typedef enum logic {
    KIND_CHAR,
    KIND_END
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [CHAR_W-1:0] char_in;
    logic              last;
  } item_t;

  typedef struct packed {
    logic [DELIM_W-1:0] delim_bytes;
    logic [LEN_W-1:0]   delim_len;
    logic [PIECE_W-1:0] piece_num;
  } cfg_t;

endpackage

/* rtl/dfe_if.sv */
`timescale 1ns / 1ps

interface dfe_in_if;
  logic                       valid;
  logic                       ready;
  logic [dfe_pkg::CHAR_W-1:0] char_in;
  logic                       char_present;
  logic                       end_of_string;

  modport source (
    output valid,
    output char_in,
    output char_present,
    output end_of_string,
    input  ready
  );

  modport sink (
    input  valid,
    input  char_in,
    input  char_present,
    input  end_of_string,
    output ready
  );
endinterface

interface dfe_out_if;
  logic                       valid;
  logic                       ready;
  logic [dfe_pkg::CHAR_W-1:0] piece_byte;
  logic                       byte_present;
  logic                       piece_end;

  modport source (
    output valid,
    output piece_byte,
    output byte_present,
    output piece_end,
    input  ready
  );

  modport sink (
    input  valid,
    input  piece_byte,
    input  byte_present,
    input  piece_end,
    output ready
  );
endinterface

/* rtl/dfe_cfg_regs.sv */
`timescale 1ns / 1ps

module dfe_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dfe_pkg::ADDR_W-1:0] paddr,
  input  logic [dfe_pkg::DATA_W-1:0] pwdata,
  output logic [dfe_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output dfe_pkg::cfg_t              cfg_o
);

  localparam int unsigned ADDR_W  = dfe_pkg::ADDR_W;
  localparam int unsigned DATA_W  = dfe_pkg::DATA_W;
  localparam int unsigned IDX_W   = dfe_pkg::IDX_W;
  localparam int unsigned DELIM_W = dfe_pkg::DELIM_W;
  localparam int unsigned LEN_W   = dfe_pkg::LEN_W;
  localparam int unsigned PIECE_W = dfe_pkg::PIECE_W;

  logic [IDX_W-1:0]   idx;
  logic               wr_en;
  logic [DELIM_W-1:0] delim_q, delim_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [PIECE_W-1:0] piece_q, piece_d;

  assign idx    = paddr[ADDR_W-1 -: IDX_W];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    delim_d = delim_q;
    len_d   = len_q;
    piece_d = piece_q;
    if (wr_en) begin
      case (idx)
        dfe_pkg::REG_DELIM_BYTES:  delim_d = pwdata[DELIM_W-1:0];
        dfe_pkg::REG_DELIM_LENGTH: len_d   = pwdata[LEN_W-1:0];
        dfe_pkg::REG_PIECE_NUMBER: piece_d = pwdata[PIECE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dfe_pkg::REG_DELIM_BYTES:  prdata = DATA_W'(delim_q);
      dfe_pkg::REG_DELIM_LENGTH: prdata = DATA_W'(len_q);
      dfe_pkg::REG_PIECE_NUMBER: prdata = DATA_W'(piece_q);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= '0;
      len_q   <= dfe_pkg::DELIM_LEN_RST;
      piece_q <= '0;
    end else begin
      delim_q <= delim_d;
      len_q   <= len_d;
      piece_q <= piece_d;
    end
  end

  assign cfg_o.delim_bytes = delim_q;
  assign cfg_o.delim_len   = len_q;
  assign cfg_o.piece_num   = piece_q;

endmodule

/* rtl/dfe_front.sv */
`timescale 1ns / 1ps

module dfe_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  dfe_in_if.sink         in_i,
  output dfe_pkg::item_t item_o,
  output logic           item_valid_o,
  input  logic           item_pop_i
);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned PTR_W  = $clog2(QDEPTH);

  dfe_pkg::item_t   queue_q [QDEPTH];
  dfe_pkg::item_t   item_new;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   count_q, count_d;
  logic             keep;
  logic             push;
  logic             pop;

  // items with neither a character nor an end mark are dropped here
  assign keep          = in_i.char_present | in_i.end_of_string;
  assign in_i.ready    = (count_q != (PTR_W + 1)'(QDEPTH));
  assign push          = in_i.valid & in_i.ready & keep;
  assign item_valid_o  = (count_q != '0);
  assign pop           = item_pop_i & item_valid_o;
  assign item_o        = queue_q[rd_ptr_q];

  always_comb begin
    item_new.kind    = in_i.char_present ? dfe_pkg::KIND_CHAR : dfe_pkg::KIND_END;
    item_new.char_in = in_i.char_in;
    item_new.last    = in_i.end_of_string;
  end

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* rtl/dfe_back.sv */
`timescale 1ns / 1ps

module dfe_back #(
  parameter int unsigned WIN_DEPTH = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dfe_pkg::cfg_t  cfg_i,
  input  dfe_pkg::item_t item_i,
  input  logic           item_valid_i,
  output logic           item_pop_o,
  dfe_out_if.source      out_o
);

  localparam int unsigned FILL_W = $clog2(WIN_DEPTH + 1);
  localparam int unsigned CW     = dfe_pkg::CHAR_W;
  localparam int unsigned LEN_W  = dfe_pkg::LEN_W;
  localparam int unsigned SEEN_W = dfe_pkg::SEEN_W;

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     win_q [WIN_DEPTH];
  logic [CW-1:0]     win_d [WIN_DEPTH];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [SEEN_W-1:0] seen_q, seen_d;
  logic              closed_q, closed_d;
  logic              out_valid_q, out_valid_d;
  logic [CW-1:0]     out_byte_q, out_byte_d;
  logic              out_present_q, out_present_d;
  logic              out_end_q, out_end_d;

  logic [FILL_W-1:0]  len_eff;
  logic [FILL_W-1:0]  len_work;
  logic [FILL_W-1:0]  shamt;
  logic [FILL_W-1:0]  wk_fill;
  logic [SEEN_W-1:0]  piece_sel;
  logic               split_en;
  logic               selected;
  logic               adv;
  logic               is_char;
  logic               ins;
  logic               prework;
  logic               do_iter;
  logic               match;
  logic [WIN_DEPTH-1:0] byte_ok;
  logic [CW-1:0]      wk_win [WIN_DEPTH];
  logic [CW-1:0]      sh_win [WIN_DEPTH];
  logic [CW-1:0]      fl_win [WIN_DEPTH];
  logic [CW-1:0]      d_byte [WIN_DEPTH];

  logic [CW-1:0]      it_win [WIN_DEPTH];
  logic [FILL_W-1:0]  it_fill;
  logic [SEEN_W-1:0]  it_seen;
  logic               it_closed;
  logic               it_emit;
  logic               it_present;
  logic [CW-1:0]      it_byte;

  always_comb begin
    if (cfg_i.delim_len > LEN_W'(WIN_DEPTH)) begin
      len_eff = FILL_W'(WIN_DEPTH);
    end else begin
      len_eff = FILL_W'(cfg_i.delim_len);
    end
  end

  assign split_en  = (len_eff != '0);
  assign len_work  = split_en ? len_eff : FILL_W'(1);
  assign piece_sel = SEEN_W'(cfg_i.piece_num);
  assign selected  = !closed_q && (seen_q == piece_sel);
  assign adv       = item_valid_i && (!out_valid_q || out_o.ready);
  assign is_char   = (state_q == ST_RUN) && (item_i.kind == dfe_pkg::KIND_CHAR) && !closed_q;
  assign ins       = is_char && (fill_q < len_work);
  assign prework   = is_char && (fill_q >= len_work);
  assign wk_fill   = ins ? fill_q + 1'b1 : fill_q;
  assign do_iter   = (wk_fill >= len_work);
  assign match     = split_en && (&byte_ok);
  assign shamt     = match ? len_eff : FILL_W'(1);

  // window with the new character placed, delimiter compare, shifts
  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      wk_win[i]  = (ins && fill_q == FILL_W'(i)) ? item_i.char_in : win_q[i];
      d_byte[i]  = cfg_i.delim_bytes[i*CW +: CW];
      byte_ok[i] = (FILL_W'(i) >= len_eff) || (wk_win[i] == d_byte[i]);
    end
    for (int i = 0; i < WIN_DEPTH; i++) begin
      sh_win[i] = '0;
      fl_win[i] = '0;
      for (int k = 0; k < WIN_DEPTH; k++) begin
        if (k == i + int'(shamt)) begin
          sh_win[i] = wk_win[k];
        end
        if (k == i + 1) begin
          fl_win[i] = win_q[k];
        end
      end
    end
  end

  // one match-or-pass step on the working window
  always_comb begin
    it_win     = wk_win;
    it_fill    = wk_fill;
    it_seen    = seen_q;
    it_closed  = closed_q;
    it_emit    = 1'b0;
    it_present = 1'b0;
    it_byte    = '0;
    if (do_iter) begin
      it_win = sh_win;
      if (match) begin
        it_fill = wk_fill - len_eff;
        if (seen_q != '1) begin
          it_seen = seen_q + 1'b1;
        end
        if (selected) begin
          it_emit   = 1'b1;
          it_closed = 1'b1;
          it_fill   = '0;
        end
      end else begin
        it_fill = wk_fill - 1'b1;
        if (selected) begin
          it_emit    = 1'b1;
          it_present = 1'b1;
          it_byte    = wk_win[0];
        end
      end
    end
  end

  always_comb begin
    state_d       = state_q;
    win_d         = win_q;
    fill_d        = fill_q;
    seen_d        = seen_q;
    closed_d      = closed_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    out_byte_d    = out_byte_q;
    out_present_d = out_present_q;
    out_end_d     = out_end_q;
    item_pop_o    = 1'b0;

    if (adv) begin
      case (state_q)
        ST_FLUSH: begin
          out_valid_d   = 1'b1;
          out_byte_d    = win_q[0];
          out_present_d = 1'b1;
          out_end_d     = (fill_q <= FILL_W'(1));
          win_d         = fl_win;
          fill_d        = fill_q - 1'b1;
          if (fill_q <= FILL_W'(1)) begin
            fill_d     = '0;
            seen_d     = '0;
            closed_d   = 1'b0;
            item_pop_o = 1'b1;
            state_d    = ST_RUN;
          end
        end
        ST_RUN: begin
          if (prework || ins) begin
            win_d    = it_win;
            fill_d   = it_fill;
            seen_d   = it_seen;
            closed_d = it_closed;
            if (it_emit) begin
              out_valid_d   = 1'b1;
              out_byte_d    = it_byte;
              out_present_d = it_present;
              out_end_d     = !it_present;
            end
            if (ins) begin
              item_pop_o = 1'b1;
              if (item_i.last) begin
                if (it_closed) begin
                  fill_d   = '0;
                  seen_d   = '0;
                  closed_d = 1'b0;
                end else if (it_seen == piece_sel && it_fill != '0) begin
                  state_d    = ST_FLUSH;
                  item_pop_o = 1'b0;
                end else begin
                  if (it_emit) begin
                    out_end_d = 1'b1;
                  end else begin
                    out_valid_d   = 1'b1;
                    out_byte_d    = '0;
                    out_present_d = 1'b0;
                    out_end_d     = 1'b1;
                  end
                  fill_d   = '0;
                  seen_d   = '0;
                  closed_d = 1'b0;
                end
              end
            end
          end else if (closed_q) begin
            item_pop_o = 1'b1;
            if (item_i.last) begin
              fill_d   = '0;
              seen_d   = '0;
              closed_d = 1'b0;
            end
          end else if (selected && fill_q != '0) begin
            state_d = ST_FLUSH;
          end else begin
            out_valid_d   = 1'b1;
            out_byte_d    = '0;
            out_present_d = 1'b0;
            out_end_d     = 1'b1;
            item_pop_o    = 1'b1;
            fill_d        = '0;
            seen_d        = '0;
            closed_d      = 1'b0;
          end
        end
        default: state_d = ST_RUN;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_RUN;
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_q[i] <= '0;
      end
      fill_q        <= '0;
      seen_q        <= '0;
      closed_q      <= 1'b0;
      out_valid_q   <= 1'b0;
      out_byte_q    <= '0;
      out_present_q <= 1'b0;
      out_end_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      win_q         <= win_d;
      fill_q        <= fill_d;
      seen_q        <= seen_d;
      closed_q      <= closed_d;
      out_valid_q   <= out_valid_d;
      out_byte_q    <= out_byte_d;
      out_present_q <= out_present_d;
      out_end_q     <= out_end_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.piece_byte   = out_byte_q;
  assign out_o.byte_present = out_present_q;
  assign out_o.piece_end    = out_end_q;

endmodule

/* rtl/delimited_field_extractor.sv */
// Splits a byte string at a configurable delimiter of up to eight bytes and
// streams out only the selected piece, closed by a single end beat. Characters
// enter a four-entry queue and are taken by the window engine at one per cycle
// sustained unless the output stalls or a flush or length change holds them;
// the engine does one delimiter compare and window shift per cycle and writes
// at most one result beat per cycle into the output register. An end-of-string
// beat for a selected piece still holding bytes in the lookahead window (up to
// MAX_DELIM-1, at most 7) waits while they are flushed one by one, and after
// delimiter length is lowered the next character waits until held bytes beyond
// the new length are shifted out. Beats with neither a character nor an end
// mark are dropped at the input. No clearing pass is needed after reset.
`timescale 1ns / 1ps

module delimited_field_extractor #(
  parameter int unsigned MAX_DELIM = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  dfe_in_if.sink                     char_i,
  dfe_out_if.source                  piece_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dfe_pkg::ADDR_W-1:0] paddr,
  input  logic [dfe_pkg::DATA_W-1:0] pwdata,
  output logic [dfe_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int unsigned WIN_DEPTH =
    (MAX_DELIM < dfe_pkg::DELIM_BYTES) ? MAX_DELIM : dfe_pkg::DELIM_BYTES;

  dfe_pkg::cfg_t  cfg;
  dfe_pkg::item_t item;
  logic           item_valid;
  logic           item_pop;

  dfe_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dfe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (char_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  dfe_back #(
    .WIN_DEPTH (WIN_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .out_o        (piece_o)
  );

endmodule

/* rtl/dfe_checker.sv */
`timescale 1ns / 1ps

module dfe_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [dfe_pkg::CHAR_W-1:0] piece_byte_i,
  input logic                       byte_present_i,
  input logic                       piece_end_i,
  input logic                       psel_i,
  input logic                       penable_i,
  input logic                       pwrite_i,
  input logic [dfe_pkg::ADDR_W-1:0] paddr_i,
  input logic [dfe_pkg::DATA_W-1:0] pwdata_i,
  input logic [dfe_pkg::DATA_W-1:0] prdata_i
);

  localparam int unsigned ADDR_W = dfe_pkg::ADDR_W;
  localparam int unsigned IDX_W  = dfe_pkg::IDX_W;
  localparam int unsigned LEN_W  = dfe_pkg::LEN_W;

  // an empty beat only ever closes a piece
  a_empty_is_end: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !byte_present_i) |-> (piece_end_i && piece_byte_i == '0)
  ) else $error("empty beat without piece end");

  // length register reads back what was last written
  a_len_readback: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (psel_i && penable_i && pwrite_i &&
     paddr_i[ADDR_W-1 -: IDX_W] == dfe_pkg::REG_DELIM_LENGTH)
    ##1 (paddr_i == $past(paddr_i))
    |-> (prdata_i[LEN_W-1:0] == $past(pwdata_i[LEN_W-1:0]))
  ) else $error("length register readback mismatch");

  a_out_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i
  ) else $error("output beat dropped while stalled");

  a_out_stable: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      ($stable(piece_byte_i) && $stable(byte_present_i) && $stable(piece_end_i))
  ) else $error("output payload changed while stalled");

endmodule

bind delimited_field_extractor dfe_checker u_dfe_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (piece_o.valid),
  .out_ready_i    (piece_o.ready),
  .piece_byte_i   (piece_o.piece_byte),
  .byte_present_i (piece_o.byte_present),
  .piece_end_i    (piece_o.piece_end),
  .psel_i         (psel),
  .penable_i      (penable),
  .pwrite_i       (pwrite),
  .paddr_i        (paddr),
  .pwdata_i       (pwdata),
  .prdata_i       (prdata)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CHAR_W      = dfe_pkg::CHAR_W;
  localparam int unsigned IDX_W       = dfe_pkg::IDX_W;
  localparam int unsigned DATA_W      = dfe_pkg::DATA_W;
  localparam int unsigned ADDR_W      = dfe_pkg::ADDR_W;
  localparam int unsigned DELIM_BYTES = dfe_pkg::DELIM_BYTES;
  localparam int unsigned DELIM_W     = dfe_pkg::DELIM_W;
  localparam int unsigned LEN_W       = dfe_pkg::LEN_W;
  localparam int unsigned PIECE_W     = dfe_pkg::PIECE_W;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int N_ITEMS      = 90;
  localparam int IDLE_PCT     = 37;
  localparam int unsigned SEEN_SAT = 17'h1FFFF;

  typedef struct packed {
    logic [CHAR_W-1:0] pbyte;
    logic              present;
    logic              pend;
  } piece_beat_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] val;
    logic [CHAR_W-1:0] c;
    logic              pres;
    logic              last;
    int                n_typed;
    piece_beat_t       typed;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  dfe_in_if  in_if ();
  dfe_out_if out_if ();

  delimited_field_extractor uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .char_i  (in_if),
    .piece_o (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state and register copy
  logic [CHAR_W-1:0]  win_q [DELIM_BYTES];
  int unsigned        fill_q;
  int unsigned        seen_q;
  bit                 closed_q;
  logic [DELIM_W-1:0] cfg_delim;
  logic [LEN_W-1:0]   cfg_len;
  logic [PIECE_W-1:0] cfg_piece;
  piece_beat_t        step_res [8];
  int                 step_n;

  piece_beat_t piece_beats_q [$];
  stim_row_t   stim_rows [$];
  int          err_cnt;
  int          quiet_cnt;
  int          n_items;
  bit          stall_en;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic void clear_string();
    foreach (win_q[i]) win_q[i] = '0;
    fill_q   = 0;
    seen_q   = 0;
    closed_q = 1'b0;
  endfunction

  function automatic void emit(logic [CHAR_W-1:0] b, logic p, logic e);
    if (step_n < 8) begin
      step_res[step_n] = '{b, p, e};
      step_n++;
    end
  endfunction

  function automatic bit in_piece();
    return !closed_q && seen_q == int'(cfg_piece);
  endfunction

  function automatic void pass_on(logic [CHAR_W-1:0] b);
    if (in_piece()) emit(b, 1'b1, 1'b0);
  endfunction

  function automatic void shift_out(int unsigned cnt);
    if (cnt > fill_q) cnt = fill_q;
    for (int unsigned i = 0; i + cnt < fill_q; i++) win_q[i] = win_q[i + cnt];
    fill_q -= cnt;
    for (int unsigned i = fill_q; i < DELIM_BYTES; i++) win_q[i] = '0;
  endfunction

  function automatic bit delim_at_front(int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      if (win_q[i] != cfg_delim[8*i +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void scan_window(int unsigned len);
    if (len == 0) begin
      for (int unsigned i = 0; i < fill_q; i++) pass_on(win_q[i]);
      shift_out(fill_q);
      return;
    end
    while (fill_q >= len && !closed_q) begin
      if (delim_at_front(len)) begin
        shift_out(len);
        if (seen_q == int'(cfg_piece)) begin
          emit('0, 1'b0, 1'b1);
          closed_q = 1'b1;
        end
        if (seen_q < SEEN_SAT) seen_q++;
      end else begin
        pass_on(win_q[0]);
        shift_out(1);
      end
    end
    if (closed_q) shift_out(fill_q);
  endfunction

  function automatic int unsigned used_len();
    return (cfg_len > DELIM_BYTES) ? DELIM_BYTES : int'(cfg_len);
  endfunction

  function automatic void predict_pieces(logic [CHAR_W-1:0] c, logic pres, logic last);
    int unsigned len;
    len    = used_len();
    step_n = 0;
    if (pres && !closed_q) begin
      scan_window(len);
      if (fill_q < DELIM_BYTES) begin
        win_q[fill_q] = c;
        fill_q++;
      end
      scan_window(len);
    end
    if (last) begin
      if (!closed_q) begin
        if (seen_q == int'(cfg_piece)) begin
          for (int unsigned i = 0; i < fill_q; i++) pass_on(win_q[i]);
          if (step_n > 0) step_res[step_n-1].pend = 1'b1;
          else emit('0, 1'b0, 1'b1);
        end else begin
          emit('0, 1'b0, 1'b1);
        end
      end
      clear_string();
    end
  endfunction

  function automatic void row_item(logic [CHAR_W-1:0] c, logic pres, logic last);
    stim_rows.push_back('{ROW_ITEM, '0, '0, c, pres, last, -1, '0});
  endfunction

  function automatic void row_exp(logic [CHAR_W-1:0] c, logic pres, logic last, int n,
                                  piece_beat_t b);
    stim_rows.push_back('{ROW_ITEM, '0, '0, c, pres, last, n, b});
  endfunction

  function automatic void row_cfg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    stim_rows.push_back('{ROW_CFG, idx, val, '0, 1'b0, 1'b0, -1, '0});
  endfunction

  task automatic send_char(input logic [CHAR_W-1:0] c, input logic pres, input logic last,
                           input int n_typed, input piece_beat_t typed);
    @(negedge clk);
    while (stall_en && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.char_in       <= c;
    in_if.char_present  <= pres;
    in_if.end_of_string <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_pieces(c, pres, last);
    if (n_typed < 0) begin
      for (int i = 0; i < step_n; i++) piece_beats_q.push_back(step_res[i]);
    end else if (n_typed > 0) begin
      piece_beats_q.push_back(typed);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (piece_beats_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      dfe_pkg::REG_DELIM_BYTES:  cfg_delim = val;
      dfe_pkg::REG_DELIM_LENGTH: cfg_len   = val[LEN_W-1:0];
      dfe_pkg::REG_PIECE_NUMBER: cfg_piece = val[PIECE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_config();
    logic [DELIM_W-1:0] d;
    logic [CHAR_W-1:0]  base;
    logic [LEN_W-1:0]   l;
    logic [PIECE_W-1:0] p;
    int                 r;
    base = CHAR_W'($urandom_range(1, 255));
    for (int i = 0; i < DELIM_BYTES; i++) begin
      d[8*i +: 8] = $urandom_range(0, 1) ? base : CHAR_W'($urandom_range(1, 255));
    end
    r = $urandom_range(0, 19);
    if (r == 0) l = '0;
    else if (r == 1) l = LEN_W'($urandom_range(9, 15));
    else if (r < 4) l = LEN_W'(DELIM_BYTES);
    else l = LEN_W'($urandom_range(1, 4));
    r = $urandom_range(0, 9);
    if (r == 0) p = '1;
    else if (r == 1) p = PIECE_W'($urandom_range(0, 65535));
    else p = PIECE_W'($urandom_range(0, 3));
    settle();
    apb_write(dfe_pkg::REG_DELIM_BYTES, d);
    apb_write(dfe_pkg::REG_DELIM_LENGTH, DATA_W'(l));
    apb_write(dfe_pkg::REG_PIECE_NUMBER, DATA_W'(p));
  endtask

  // pieces of random content joined by the delimiter, with some noise beats
  task automatic random_string();
    logic [CHAR_W-1:0] s [$];
    int                npieces;
    int                m;
    int unsigned       len;
    len     = used_len();
    npieces = $urandom_range(1, 4);
    for (int p = 0; p < npieces; p++) begin
      if (p > 0) begin
        for (int unsigned k = 0; k < len; k++) s.push_back(cfg_delim[8*k +: 8]);
      end
      m = $urandom_range(0, 4);
      for (int j = 0; j < m; j++) begin
        if (len > 0 && $urandom_range(0, 9) < 4)
          s.push_back(cfg_delim[8*$urandom_range(0, len-1) +: 8]);
        else
          s.push_back(CHAR_W'($urandom_range(1, 255)));
      end
    end
    if (s.size() == 0) begin
      send_char(CHAR_W'($urandom_range(1, 255)), 1'b0, 1'b1, -1, '0);
      n_items++;
    end else begin
      foreach (s[i]) begin
        if ($urandom_range(0, 9) == 0)
          send_char(CHAR_W'($urandom_range(1, 255)), 1'b0, 1'b0, -1, '0);
        send_char(s[i], 1'b1, i == s.size() - 1, -1, '0);
        n_items++;
      end
    end
  endtask

  always @(negedge clk) begin
    out_if.ready <= !stall_en || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    piece_beat_t got;
    piece_beat_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.piece_byte, out_if.byte_present, out_if.piece_end};
      if (piece_beats_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat byte %02h present %b end %b",
                                  got.pbyte, got.present, got.pend));
      end else begin
        want = piece_beats_q.pop_front();
        if (got !== want)
          report_mismatch($sformatf("byte %02h/%02h present %b/%b end %b/%b (got/exp)",
                                    got.pbyte, want.pbyte, got.present, want.present,
                                    got.pend, want.pend));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
      quiet_cnt <= 0;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
      if (quiet_cnt >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int str_cnt;
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.char_in       = '0;
    in_if.char_present  = 1'b0;
    in_if.end_of_string = 1'b0;
    out_if.ready        = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    err_cnt             = 0;
    quiet_cnt           = 0;
    n_items             = 0;
    str_cnt             = 0;
    stall_en            = 1'b1;
    cfg_delim           = '0;
    cfg_len             = dfe_pkg::DELIM_LEN_RST;
    cfg_piece           = '0;
    clear_string();

    // after reset: delimiter is a single zero byte, piece zero
    row_exp(8'h61, 1'b1, 1'b1, 1, '{8'h61, 1'b1, 1'b1});
    row_exp(8'h00, 1'b1, 1'b0, 1, '{8'h00, 1'b0, 1'b1});
    row_exp(8'h62, 1'b1, 1'b1, 0, '0);
    row_exp(8'h63, 1'b0, 1'b1, 1, '{8'h00, 1'b0, 1'b1});
    row_exp(8'h64, 1'b0, 1'b0, 0, '0);
    // two-byte delimiter, second piece closed by a delimiter
    row_cfg(dfe_pkg::REG_DELIM_BYTES, 64'h6261);
    row_cfg(dfe_pkg::REG_DELIM_LENGTH, 64'd2);
    row_cfg(dfe_pkg::REG_PIECE_NUMBER, 64'd1);
    row_item(8'h61, 1'b1, 1'b0);
    row_item(8'h62, 1'b1, 1'b0);
    row_item(8'h79, 1'b1, 1'b0);
    row_item(8'h79, 1'b1, 1'b0);
    row_item(8'h61, 1'b1, 1'b0);
    row_item(8'h62, 1'b1, 1'b0);
    row_item(8'h7a, 1'b1, 1'b1);
    // full-width delimiter, end of string flushes the whole window
    row_cfg(dfe_pkg::REG_DELIM_BYTES, '1);
    row_cfg(dfe_pkg::REG_DELIM_LENGTH, 64'd8);
    row_cfg(dfe_pkg::REG_PIECE_NUMBER, 64'd0);
    for (int i = 0; i < 7; i++) row_item(8'hff, 1'b1, 1'b0);
    row_item(8'h01, 1'b1, 1'b1);
    // oversized length, piece that never shows up
    row_cfg(dfe_pkg::REG_DELIM_LENGTH, 64'd15);
    row_cfg(dfe_pkg::REG_PIECE_NUMBER, 64'hffff);
    row_exp(8'h71, 1'b1, 1'b1, 1, '{8'h00, 1'b0, 1'b1});
    // length dropped to zero with bytes held in the window
    row_cfg(dfe_pkg::REG_DELIM_BYTES, 64'h434241);
    row_cfg(dfe_pkg::REG_DELIM_LENGTH, 64'd3);
    row_cfg(dfe_pkg::REG_PIECE_NUMBER, 64'd0);
    row_item(8'h78, 1'b1, 1'b0);
    row_item(8'h41, 1'b1, 1'b0);
    row_item(8'h42, 1'b1, 1'b0);
    row_cfg(dfe_pkg::REG_DELIM_LENGTH, 64'd0);
    row_item(8'h43, 1'b1, 1'b1);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        settle();
        apb_write(stim_rows[i].idx, stim_rows[i].val);
      end else begin
        send_char(stim_rows[i].c, stim_rows[i].pres, stim_rows[i].last,
                  stim_rows[i].n_typed, stim_rows[i].typed);
      end
    end

    n_items = 0;
    while (n_items < N_ITEMS) begin
      if (str_cnt % 3 == 0) random_config();
      stall_en = !(n_items >= 40 && n_items < 70);
      random_string();
      str_cnt++;
    end
    stall_en = 1'b1;
    settle();

    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/dfe_pkg.sv
rtl/dfe_if.sv
rtl/dfe_cfg_regs.sv
rtl/dfe_front.sv
rtl/dfe_back.sv
rtl/delimited_field_extractor.sv
rtl/dfe_checker.sv
tb/tb_top.sv
